FILE: sv/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types and constants of the bitmap slot allocator
// ----------------------------------------------------------------------------
package bsa_pkg;

   // pool size, a power of two from 8 to 4096
   localparam int MAX_SLOTS  = 1024;
   // limit on the slot field of the item
   localparam int FIELD_SLOTS = 1024;
   localparam int CAP_SLOTS  = (MAX_SLOTS < FIELD_SLOTS) ? MAX_SLOTS : FIELD_SLOTS;

   localparam int WORD_BITS  = (MAX_SLOTS >= 64) ? 32 : MAX_SLOTS / 2;
   localparam int WORD_LOG   = $clog2(WORD_BITS);
   localparam int WORDS      = MAX_SLOTS / WORD_BITS;
   localparam int WADDR_W    = $clog2(WORDS);
   localparam int SLOT_W     = $clog2(MAX_SLOTS);
   localparam int COUNT_W    = $clog2(MAX_SLOTS + 1);

   localparam int CSR_W      = 11;
   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(800);

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } bsa_func_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_RANGE     = 2'd2
   } bsa_status_type;

   typedef struct packed {
      bsa_func_type func;
      logic [9:0]   slot_index;
   } bsa_req_type;

   typedef struct packed {
      bsa_status_type status;
      logic [9:0]     granted_slot;
      logic [10:0]    used_count;
   } bsa_rsp_type;

   // bitmap memory port controls
   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } bsa_ram_ctl_type;

endpackage

FILE: sv/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// first-fit slot allocator over a used-mark bitmap held in a word memory
// ----------------------------------------------------------------------------
// an accepted item waits in the read state for its bitmap word and for a free result
// register; no new item is taken until the read-modify-write of its bitmap word is done
// a per-word full summary picks the word for an allocate in the accept cycle
// reset: synchronous; the per-word valid flags clear at once, so the bitmap reads
// all free right after reset with no clearing pass; slot limit resets to 800
// ----------------------------------------------------------------------------
module bitmap_slot_allocator (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bsa_pkg::bsa_req_type          req_item,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bsa_pkg::bsa_rsp_type          rsp_item,
   // slot limit register
   input  logic                          csr_wr_en,
   input  logic [bsa_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int CMP_W = (bsa_pkg::SLOT_W + 1 > 11) ? bsa_pkg::SLOT_W + 1 : 11;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   // control state
   state_type                       state_ff, state_in;
   logic [bsa_pkg::CSR_W-1:0]       limit_ff;
   logic [bsa_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [bsa_pkg::WORDS-1:0]       full_ff, full_in;      // word has no free bit
   logic [bsa_pkg::WORDS-1:0]       wvalid_ff, wvalid_in;  // word written since reset
   logic                            rsp_valid_ff, rsp_valid_in;

   // per-item registers
   bsa_pkg::bsa_func_type           func_ff;
   logic [9:0]                      idx_ff;
   logic [bsa_pkg::WADDR_W-1:0]     waddr_ff;
   logic                            any_free_ff;
   bsa_pkg::bsa_rsp_type            rsp_ff, rsp_in;

   // memory interface
   bsa_pkg::bsa_ram_ctl_type        ram_ctl;
   logic [bsa_pkg::WORD_BITS-1:0]   rd_data;

   bsa_map_ram u_map_ram (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .rd_data (rd_data)
   );

   // active limit, saturated to the pool size
   logic [bsa_pkg::CSR_W-1:0] lim;
   assign lim = (limit_ff > bsa_pkg::CSR_W'(bsa_pkg::CAP_SLOTS))
                ? bsa_pkg::CSR_W'(bsa_pkg::CAP_SLOTS) : limit_ff;

   logic req_accept;
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   // lowest word with a free bit
   logic [bsa_pkg::WADDR_W-1:0] free_word;
   always_comb begin
      free_word = '0;
      for (int i = bsa_pkg::WORDS - 1; i >= 0; i--) begin
         if (!full_ff[i]) free_word = bsa_pkg::WADDR_W'(i);
      end
   end

   // word as stored; never-written words read free
   logic [bsa_pkg::WORD_BITS-1:0] word;
   assign word = wvalid_ff[waddr_ff] ? rd_data : '0;

   // lowest free bit of that word
   logic [bsa_pkg::WORD_LOG-1:0] free_bit;
   always_comb begin
      free_bit = '0;
      for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) free_bit = bsa_pkg::WORD_LOG'(i);
      end
   end

   logic [bsa_pkg::SLOT_W-1:0]    alloc_slot;
   logic [bsa_pkg::WORD_LOG-1:0]  free_req_bit;
   logic                          alloc_ok;
   logic                          idx_in_range;
   logic                          finish;
   logic [bsa_pkg::WORD_BITS-1:0] new_word;

   assign alloc_slot   = {waddr_ff, free_bit};
   assign alloc_ok     = any_free_ff && (CMP_W'(alloc_slot) < CMP_W'(lim));
   assign idx_in_range = CMP_W'(idx_ff) < CMP_W'(lim);
   assign free_req_bit = idx_ff[bsa_pkg::WORD_LOG-1:0];
   // result register free, or being emptied this cycle
   assign finish       = (state_ff == S_READ) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      wvalid_in    = wvalid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      new_word     = word;

      ram_ctl         = '0;
      ram_ctl.rd_en   = req_accept;
      ram_ctl.rd_addr = (req_item.func == bsa_pkg::FUNC_ALLOC)
                        ? free_word
                        : bsa_pkg::WADDR_W'(bsa_pkg::SLOT_W'(req_item.slot_index) >>
                                            bsa_pkg::WORD_LOG);
      ram_ctl.wr_addr = waddr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_READ;
         end
         S_READ: begin
            if (finish) begin
               rsp_in.status       = bsa_pkg::ST_DONE;
               rsp_in.granted_slot = '0;
               if (func_ff == bsa_pkg::FUNC_ALLOC) begin
                  if (alloc_ok) begin
                     new_word[free_bit]  = 1'b1;
                     ram_ctl.wr_en       = 1'b1;
                     count_in            = count_ff + bsa_pkg::COUNT_W'(1);
                     rsp_in.granted_slot = 10'(alloc_slot);
                  end else begin
                     rsp_in.status = bsa_pkg::ST_EXHAUSTED;
                  end
               end else begin
                  if (!idx_in_range) begin
                     rsp_in.status = bsa_pkg::ST_RANGE;
                  end else if (word[free_req_bit]) begin
                     new_word[free_req_bit] = 1'b0;
                     ram_ctl.wr_en          = 1'b1;
                     count_in               = count_ff - bsa_pkg::COUNT_W'(1);
                  end
               end
               if (ram_ctl.wr_en) begin
                  full_in[waddr_ff]   = &new_word;
                  wvalid_in[waddr_ff] = 1'b1;
               end
               rsp_in.used_count = 11'(count_in);
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      ram_ctl.wr_data = new_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= bsa_pkg::CSR_RESET;
         count_ff     <= '0;
         full_ff      <= '0;
         wvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         full_ff      <= full_in;
         wvalid_ff    <= wvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         func_ff     <= req_item.func;
         idx_ff      <= req_item.slot_index;
         waddr_ff    <= ram_ctl.rd_addr;
         any_free_ff <= ~&full_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // the mark count never passes the pool size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bsa_pkg::COUNT_W'(bsa_pkg::MAX_SLOTS))
      else $error("mark count above pool size");

   // bitmap is written only while an item finishes
   a_write_in_read: assert property (@(posedge clock) disable iff (reset)
      ram_ctl.wr_en |-> finish)
      else $error("bitmap write outside item completion");

   // entering the read state needs an accepted item
   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && state_in == S_READ) |-> req_accept)
      else $error("read state without accepted item");

   // a failed request hands out no slot
   a_no_grant_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != bsa_pkg::ST_DONE) |-> rsp_ff.granted_slot == '0)
      else $error("slot granted on failed request");

   // count moves only when an item finishes
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !finish |=> $stable(count_ff))
      else $error("count changed without an item");

endmodule

FILE: sv/bsa_map_ram.sv
// ----------------------------------------------------------------------------
// bsa_map_ram
// used-mark bitmap storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bsa_map_ram (
   input  logic                            clock,
   input  bsa_pkg::bsa_ram_ctl_type        ram_ctl,
   output logic [bsa_pkg::WORD_BITS-1:0]   rd_data
);

   logic [bsa_pkg::WORD_BITS-1:0] mem [bsa_pkg::WORDS];
   logic [bsa_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_ctl.wr_en) begin
         mem[ram_ctl.wr_addr] <= ram_ctl.wr_data;
      end
      if (ram_ctl.rd_en) begin
         rd_data_ff <= mem[ram_ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/bitmap_slot_allocator_test.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_test
// self-checking bench: directed and random allocate/free traffic against a
// bit-level predictor of the used-mark map, with random idling on both sides
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   // kinds of row in the directed table
   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } pool_row_kind_type;

   // one directed step: an item, or a slot limit write between items
   typedef struct {
      pool_row_kind_type       kind;
      bsa_pkg::bsa_func_type   func;
      logic [9:0]              slot_index;
      logic [10:0]             limit;
      bit                      has_rsp;
      bsa_pkg::bsa_status_type status;
      logic [9:0]              granted_slot;
      logic [10:0]             used_count;
   } pool_row_type;

   // one random stretch: idle phase, limit setting, allocate share, item count
   typedef struct {
      int          phase;
      logic [10:0] limit;
      int          alloc_pct;
      int          items;
   } pool_segment_type;

   localparam int DIRECTED_ROWS = 30;
   localparam int SEGMENTS      = 10;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   bsa_pkg::bsa_req_type          req_item;
   logic                          rsp_valid;
   logic                          rsp_stall;
   bsa_pkg::bsa_rsp_type          rsp_item;
   logic                          csr_wr_en;
   logic [bsa_pkg::CSR_W-1:0]     csr_wr_data;

   // predictor state: used marks, their count and the limit register
   bit                            slot_marks [0:bsa_pkg::MAX_SLOTS-1];
   int unsigned                   marks_total;
   logic [bsa_pkg::CSR_W-1:0]     pool_limit_cfg;

   // results owed by the block, oldest first
   bsa_pkg::bsa_rsp_type slot_replies_due [$];

   // typed expectation travelling with the item on offer
   bit                   typed_check;
   bsa_pkg::bsa_rsp_type typed_rsp;

   int errors;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;

   // directed table; rows with has_rsp clear are left to the predictor
   pool_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // fresh pool at the reset limit of 800
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1023, 11'd0, 1'b1, bsa_pkg::ST_RANGE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd800, 11'd0, 1'b1, bsa_pkg::ST_RANGE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd799, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      // index is ignored on allocate
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd1023, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd1},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd1, 11'd2},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd2, 11'd3},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd2},
      // first fit takes the hole just opened
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd2},
      // freeing a slot that is already free
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd2},
      // zero limit: nothing can be granted or freed
      '{ROW_CSR, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_EXHAUSTED, 10'd0, 11'd2},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_RANGE, 10'd0, 11'd2},
      // limit lowered below a marked slot
      '{ROW_CSR, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd2, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd1, 11'd3},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_EXHAUSTED, 10'd0, 11'd3},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd2, 11'd0, 1'b1, bsa_pkg::ST_RANGE, 10'd0, 11'd3},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd2},
      // oversized limit saturates to the pool size
      '{ROW_CSR, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd2047, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1023, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd2},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd2, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd1},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd1, 11'd2},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd682, 11'd0, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      // single-slot pool
      '{ROW_CSR, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd1, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_EXHAUSTED, 10'd0, 11'd2},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd1, 11'd0, 1'b1, bsa_pkg::ST_RANGE, 10'd0, 11'd2},
      '{ROW_ITEM, bsa_pkg::FUNC_FREE, 10'd0, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd1},
      '{ROW_ITEM, bsa_pkg::FUNC_ALLOC, 10'd341, 11'd0, 1'b1, bsa_pkg::ST_DONE, 10'd0, 11'd2},
      '{ROW_CSR, bsa_pkg::FUNC_ALLOC, 10'd0, 11'd1024, 1'b0, bsa_pkg::ST_DONE, 10'd0, 11'd0}
   };

   // random stretches: fill runs push grants past slot 512, drain runs and
   // tiny or zero limits hit exhaustion and range rejects
   pool_segment_type random_plan [0:SEGMENTS-1] = '{
      '{0, 11'd1024, 95, 300},
      '{0, 11'd2047, 90, 250},
      '{0, 11'd8,    50,  60},
      '{0, 11'd0,    50,  30},
      '{1, 11'd1024, 95, 200},
      '{1, 11'd1024, 20, 150},
      '{1, 11'd513,  60,  80},
      '{2, 11'd1,    50,  40},
      '{2, 11'd600,  60, 200},
      '{2, 11'd1024, 97, 450}
   };

   // idle shares per phase: sender-light, receiver-light, then none
   int send_pct_by_phase [0:2] = '{28, 70, 0};
   int recv_pct_by_phase [0:2] = '{70, 28, 0};

   bitmap_slot_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("bitmap_slot_allocator_test: done, errors");
      $finish;
   end

   // apply one item to the predictor and return the result it owes
   function automatic bsa_pkg::bsa_rsp_type predict_pool_op(bsa_pkg::bsa_req_type op);
      int unsigned lim;
      bsa_pkg::bsa_rsp_type r;
      lim = (pool_limit_cfg > bsa_pkg::CAP_SLOTS) ? bsa_pkg::CAP_SLOTS : pool_limit_cfg;
      r.status       = bsa_pkg::ST_DONE;
      r.granted_slot = '0;
      if (op.func == bsa_pkg::FUNC_ALLOC) begin
         // first fit below the active limit
         r.status = bsa_pkg::ST_EXHAUSTED;
         for (int unsigned i = 0; i < lim; i++) begin
            if (!slot_marks[i]) begin
               slot_marks[i]  = 1'b1;
               marks_total++;
               r.status       = bsa_pkg::ST_DONE;
               r.granted_slot = 10'(i);
               break;
            end
         end
      end else if (op.slot_index >= lim) begin
         r.status = bsa_pkg::ST_RANGE;
      end else if (slot_marks[op.slot_index]) begin
         slot_marks[op.slot_index] = 1'b0;
         marks_total--;
      end
      r.used_count = 11'(marks_total);
      return r;
   endfunction

   // predictor and result checker, both on the rising edge
   always @(posedge clock) begin
      bsa_pkg::bsa_rsp_type want;
      bsa_pkg::bsa_rsp_type got;
      if (reset) begin
         foreach (slot_marks[i]) slot_marks[i] = 1'b0;
         marks_total    = 0;
         pool_limit_cfg = bsa_pkg::CSR_RESET;
      end else begin
         // the result leaving now belongs to an earlier item, so check first
         if (rsp_valid && !rsp_stall) begin
            got = rsp_item;
            if (slot_replies_due.size() == 0) begin
               $display("%0t: unexpected result status %0d slot %0d count %0d",
                        $time, got.status, got.granted_slot, got.used_count);
               errors++;
            end else begin
               want = slot_replies_due.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.granted_slot !== want.granted_slot) begin
                  $display("%0t: granted_slot expected %0d, got %0d",
                           $time, want.granted_slot, got.granted_slot);
                  errors++;
               end
               if (got.used_count !== want.used_count) begin
                  $display("%0t: used_count expected %0d, got %0d",
                           $time, want.used_count, got.used_count);
                  errors++;
               end
            end
         end
         if (csr_wr_en)
            pool_limit_cfg = csr_wr_data;
         if (req_valid && !req_stall) begin
            want = predict_pool_op(req_item);
            // rows with a hand-written answer are held to it
            slot_replies_due.push_back(typed_check ? typed_rsp : want);
         end
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // offer one item, with random gaps before it; returns at the falling edge
   // after it was taken, valid still high so a following item can follow on
   task automatic offer_pool_op(input bsa_pkg::bsa_req_type op, input bit has_rsp,
                                input bsa_pkg::bsa_rsp_type rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_item    <= op;
      typed_check <= has_rsp;
      typed_rsp   <= rsp;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // write the slot limit once the block has gone quiet
   task automatic set_slot_limit(input logic [bsa_pkg::CSR_W-1:0] value);
      req_valid <= 1'b0;
      while (slot_replies_due.size() != 0) @(negedge clock);
      // settling margin before the write
      repeat (2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      bsa_pkg::bsa_req_type op;
      bsa_pkg::bsa_rsp_type rsp;
      int unsigned lim_eff;
      errors        = 0;
      hold_request  = 0;
      send_idle_pct = send_pct_by_phase[0];
      recv_idle_pct = recv_pct_by_phase[0];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      typed_check   = 1'b0;
      typed_rsp     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            set_slot_limit(directed_rows[r].limit);
         end else begin
            op.func             = directed_rows[r].func;
            op.slot_index       = directed_rows[r].slot_index;
            rsp.status          = directed_rows[r].status;
            rsp.granted_slot    = directed_rows[r].granted_slot;
            rsp.used_count      = directed_rows[r].used_count;
            offer_pool_op(op, directed_rows[r].has_rsp, rsp);
         end
      end

      // random part
      rsp = '0;
      foreach (random_plan[s]) begin
         set_slot_limit(random_plan[s].limit);
         send_idle_pct = send_pct_by_phase[random_plan[s].phase];
         recv_idle_pct = recv_pct_by_phase[random_plan[s].phase];
         // long receiver hold-off while items keep coming, to back the block up
         if (s == 0)
            hold_request = 400;
         lim_eff = (random_plan[s].limit > bsa_pkg::CAP_SLOTS)
                   ? bsa_pkg::CAP_SLOTS : random_plan[s].limit;
         repeat (random_plan[s].items) begin
            if ($urandom_range(99) < random_plan[s].alloc_pct) begin
               op.func       = bsa_pkg::FUNC_ALLOC;
               op.slot_index = 10'($urandom_range(1023));
            end else begin
               op.func = bsa_pkg::FUNC_FREE;
               // mostly inside the limit, some anywhere for range rejects
               if (lim_eff == 0 || $urandom_range(99) < 15)
                  op.slot_index = 10'($urandom_range(1023));
               else
                  op.slot_index = 10'($urandom_range(lim_eff - 1));
            end
            offer_pool_op(op, 1'b0, rsp);
         end
      end

      // drain and settle
      req_valid <= 1'b0;
      while (slot_replies_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("bitmap_slot_allocator_test: done, clean");
      else
         $display("bitmap_slot_allocator_test: done, errors");
      $finish;
   end

endmodule
